FILE: rtl/sat_pkg.sv
// Package for the shell argument tokenizer: character constants, result codes,
// the result record type and the table capacity.
// No dependencies; every other file of the block imports it.
package sat_pkg;

  // Hard capacity of the argument table; the register value is clamped to it.
  localparam logic [6:0] MaxArgs = 7'd64;

  // Result kinds.
  localparam logic [1:0] KIND_BYTE  = 2'd0;
  localparam logic [1:0] KIND_END   = 2'd1;
  localparam logic [1:0] KIND_DONE  = 2'd2;
  localparam logic [1:0] KIND_ERROR = 2'd3;

  // Error codes.
  localparam logic [1:0] ERR_QUOTE    = 2'd0;
  localparam logic [1:0] ERR_ESCAPE   = 2'd1;
  localparam logic [1:0] ERR_TOO_MANY = 2'd2;

  // Open quote state.
  localparam logic [1:0] QUOTE_NONE   = 2'd0;
  localparam logic [1:0] QUOTE_SINGLE = 2'd1;
  localparam logic [1:0] QUOTE_DOUBLE = 2'd2;

  // Characters of interest.
  localparam logic [7:0] CHAR_NUL    = 8'h00;
  localparam logic [7:0] CHAR_SPACE  = 8'h20;
  localparam logic [7:0] CHAR_TAB    = 8'h09;
  localparam logic [7:0] CHAR_BSLASH = 8'h5C;
  localparam logic [7:0] CHAR_SQUOTE = 8'h27;
  localparam logic [7:0] CHAR_DQUOTE = 8'h22;

  // One result record as it travels to the output.
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic [6:0] index;
    logic [1:0] code;
    logic       last;
  } result_t;

endpackage

FILE: rtl/sat_core.sv
// Tokenizer state and the per-byte step logic producing up to two results.
// Depends on sat_pkg.
module sat_core
  import sat_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_en_i,
  input  logic [7:0] byte_i,
  input  logic [6:0] max_args_i,
  output logic [1:0] res_cnt_o,
  output result_t    res0_o,
  output result_t    res1_o
);

  logic       in_arg_q, in_arg_d;
  logic [1:0] quote_q, quote_d;
  logic       esc_q, esc_d;
  logic [6:0] count_q, count_d;
  logic       disc_q, disc_d;

  logic [6:0] cap;
  logic       blank;
  logic       go;
  logic [6:0] idx;
  logic [7:0] close_char;

  assign cap   = (max_args_i < MaxArgs) ? max_args_i : MaxArgs;
  assign blank = (byte_i == CHAR_SPACE) || (byte_i == CHAR_TAB);

  // Step logic for one byte, following the quoting and escape rules.
  always_comb begin
    in_arg_d   = in_arg_q;
    quote_d    = quote_q;
    esc_d      = esc_q;
    count_d    = count_q;
    disc_d     = disc_q;
    res_cnt_o  = 2'd0;
    res0_o     = '0;
    res1_o     = '0;
    go         = 1'b0;
    idx        = '0;
    close_char = (quote_q == QUOTE_SINGLE) ? CHAR_SQUOTE : CHAR_DQUOTE;

    if (byte_i == CHAR_NUL) begin
      // Line end: report the outcome unless discarding, then clear the line.
      if (!disc_q) begin
        if (esc_q) begin
          res0_o    = '{KIND_ERROR, 8'd0, count_q, ERR_ESCAPE, 1'b0};
          res_cnt_o = 2'd1;
        end else if (quote_q != QUOTE_NONE) begin
          res0_o    = '{KIND_ERROR, 8'd0, count_q, ERR_QUOTE, 1'b0};
          res_cnt_o = 2'd1;
        end else if (in_arg_q) begin
          res0_o    = '{KIND_END, 8'd0, count_q - 7'd1, ERR_QUOTE, 1'b0};
          res1_o    = '{KIND_DONE, 8'd0, count_q, ERR_QUOTE, 1'b0};
          res_cnt_o = 2'd2;
        end else begin
          res0_o    = '{KIND_DONE, 8'd0, count_q, ERR_QUOTE, 1'b0};
          res_cnt_o = 2'd1;
        end
      end
      in_arg_d = 1'b0;
      quote_d  = QUOTE_NONE;
      esc_d    = 1'b0;
      count_d  = '0;
      disc_d   = 1'b0;
    end else if (!disc_q) begin
      go = 1'b1;
      // A non-blank byte between arguments starts one, if there is room.
      if (!in_arg_q) begin
        if (blank) begin
          go = 1'b0;
        end else if (count_q >= cap) begin
          disc_d    = 1'b1;
          res0_o    = '{KIND_ERROR, 8'd0, count_q, ERR_TOO_MANY, 1'b0};
          res_cnt_o = 2'd1;
          go        = 1'b0;
        end else begin
          count_d  = count_q + 7'd1;
          in_arg_d = 1'b1;
          quote_d  = QUOTE_NONE;
          esc_d    = 1'b0;
        end
      end
      idx = count_d - 7'd1;
      // Inside an argument: escapes, quotes, separators and plain bytes.
      if (go) begin
        if (esc_d) begin
          esc_d     = 1'b0;
          res0_o    = '{KIND_BYTE, byte_i, idx, ERR_QUOTE, 1'b0};
          res_cnt_o = 2'd1;
        end else if (byte_i == CHAR_BSLASH) begin
          esc_d = 1'b1;
        end else if (quote_d != QUOTE_NONE) begin
          if (byte_i == close_char) begin
            quote_d = QUOTE_NONE;
          end else begin
            res0_o    = '{KIND_BYTE, byte_i, idx, ERR_QUOTE, 1'b0};
            res_cnt_o = 2'd1;
          end
        end else if (byte_i == CHAR_SQUOTE) begin
          quote_d = QUOTE_SINGLE;
        end else if (byte_i == CHAR_DQUOTE) begin
          quote_d = QUOTE_DOUBLE;
        end else if (blank) begin
          res0_o    = '{KIND_END, 8'd0, idx, ERR_QUOTE, 1'b0};
          res_cnt_o = 2'd1;
          in_arg_d  = 1'b0;
        end else begin
          res0_o    = '{KIND_BYTE, byte_i, idx, ERR_QUOTE, 1'b0};
          res_cnt_o = 2'd1;
        end
      end
    end

    // Mark the final result caused by this byte.
    case (res_cnt_o)
      2'd1:    res0_o.last = 1'b1;
      2'd2:    res1_o.last = 1'b1;
      default: ;
    endcase
  end

  // Line state advances only when a byte is processed.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_arg_q <= 1'b0;
      quote_q  <= QUOTE_NONE;
      esc_q    <= 1'b0;
      count_q  <= '0;
      disc_q   <= 1'b0;
    end else if (step_en_i) begin
      in_arg_q <= in_arg_d;
      quote_q  <= quote_d;
      esc_q    <= esc_d;
      count_q  <= count_d;
      disc_q   <= disc_d;
    end
  end

endmodule

FILE: rtl/sat_fifo.sv
// Four-entry queue taking up to two results per cycle with room, giving one.
// Depends on sat_pkg.
module sat_fifo
  import sat_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [1:0] push_cnt_i,
  input  result_t    push0_i,
  input  result_t    push1_i,
  output logic       room_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output result_t    out_o
);

  result_t    mem_q [4];
  logic [1:0] wptr_q, rptr_q;
  logic [2:0] cnt_q, cnt_d;
  logic       pop;
  logic [1:0] wptr_nxt;

  assign room_o      = (cnt_q <= 3'd2);
  assign out_valid_o = (cnt_q != 3'd0);
  assign out_o       = mem_q[rptr_q];
  assign pop         = out_valid_o && out_ready_i;
  assign wptr_nxt    = wptr_q + 2'd1;
  assign cnt_d       = cnt_q + {1'b0, push_cnt_i} - {2'b00, pop};

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_q + push_cnt_i;
      rptr_q <= rptr_q + {1'b0, pop};
      cnt_q  <= cnt_d;
    end
  end

  // Entry storage; the second result goes into the slot after the first.
  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) begin
      mem_q[wptr_q] <= push0_i;
    end
    if (push_cnt_i == 2'd2) begin
      mem_q[wptr_nxt] <= push1_i;
    end
  end

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 3'd4) else $error("result queue count out of range");
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_cnt_i != 2'd0) |-> (cnt_q <= 3'd2))
    else $error("results pushed without room");
  a_cnt_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_cnt_i == 2'd0 && !pop) |=> $stable(cnt_q))
    else $error("result queue count moved without a transfer");
`endif

endmodule

FILE: rtl/shell_argument_tokenizer.sv
// Shell argument tokenizer: splits a zero-terminated command line into arguments.
// Each byte is registered, then stepped into the result queue once the queue has room.
// Throughput: one byte per cycle while the result queue has room; a line end
// closing an argument gives two results, sent one at a time by the single output port.
// Reset (rst_ni, asynchronous, active low) clears the line state and sets the
// argument limit register to 64.
module shell_argument_tokenizer
  import sat_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] result_kind_o,
  output logic [7:0] out_byte_o,
  output logic [6:0] arg_index_o,
  output logic [1:0] error_code_o,
  output logic       last_of_run_o,
  input  logic       cfg_we_i,
  input  logic [6:0] cfg_wdata_i
);

  logic [6:0] max_args_q;
  logic       byte_vld_q;
  logic [7:0] byte_q;
  logic       room;
  logic       step_en;
  logic [1:0] res_cnt;
  logic [1:0] push_cnt;
  result_t    res0, res1, head;

  assign step_en    = byte_vld_q && room;
  assign in_ready_o = !byte_vld_q || step_en;
  assign push_cnt   = step_en ? res_cnt : 2'd0;

  // Argument limit register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_args_q <= MaxArgs;
    end else if (cfg_we_i) begin
      max_args_q <= cfg_wdata_i;
    end
  end

  // Input register: holds one byte until the step logic takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      byte_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q <= in_byte_i;
    end
  end

  sat_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_en_i  (step_en),
    .byte_i     (byte_q),
    .max_args_i (max_args_q),
    .res_cnt_o  (res_cnt),
    .res0_o     (res0),
    .res1_o     (res1)
  );

  sat_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_cnt_i  (push_cnt),
    .push0_i     (res0),
    .push1_i     (res1),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (head)
  );

  // Result fields.
  assign result_kind_o = head.kind;
  assign out_byte_o    = head.data;
  assign arg_index_o   = head.index;
  assign error_code_o  = head.code;
  assign last_of_run_o = head.last;

endmodule
